### hdl/ccd_pkg.sv
// Shared types and constants for the coin change dispenser.
// No dependencies; compiled first.
package ccd_pkg;

  localparam int NUM_DENOMS       = 5;
  localparam int DENOM_W          = 16;
  localparam int AMT_W            = 20;
  localparam int CFG_IDX_W        = 3;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int AMOUNT_WIDTH_DEF = 20;

  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_REQUEST = 2'd1,
    OP_TICK    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef logic [DENOM_W-1:0]                    denom_t;
  typedef logic [NUM_DENOMS-1:0][DENOM_W-1:0]    denom_vec_t;
  typedef logic [NUM_DENOMS-1:0]                 mask_t;
  typedef logic [CFG_IDX_W-1:0]                  cfg_idx_t;

  // index 0 is the largest bill, dispensed first
  localparam denom_vec_t DENOM_RESET = {16'd20, 16'd50, 16'd2000, 16'd5000, 16'd10000};

endpackage

### hdl/ccd_ifs.sv
// Valid/ready channel interfaces: input item, result item, config write.
// Depends on ccd_pkg.
interface ccd_in_if;
  logic             valid;
  logic             ready;
  ccd_pkg::op_t     op;
  logic [ccd_pkg::AMT_W-1:0] amount;

  modport source (output valid, op, amount, input ready);
  modport sink   (input valid, op, amount, output ready);
endinterface

interface ccd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  ccd_pkg::mask_t            dispensed_mask;
  logic [ccd_pkg::AMT_W-1:0] remaining;
  logic                      done_res;
  logic                      stuck;

  modport source (output valid, accepted, dispensed_mask, remaining, done_res, stuck,
                  input ready);
  modport sink   (input valid, accepted, dispensed_mask, remaining, done_res, stuck,
                  output ready);
endinterface

interface ccd_cfg_if;
  logic              valid;
  logic              ready;
  ccd_pkg::cfg_idx_t index;
  ccd_pkg::denom_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/ccd_pass.sv
// One greedy dispense pass: denominations in index order from index 0, at most one each.
// Depends on ccd_pkg.
module ccd_pass #(
  parameter int AMOUNT_WIDTH = ccd_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic [AMOUNT_WIDTH-1:0] pend_i,
  input  ccd_pkg::denom_vec_t     denom_i,
  input  ccd_pkg::mask_t          in_stock_i,
  output logic [AMOUNT_WIDTH-1:0] pend_o,
  output ccd_pkg::mask_t          mask_o
);

  localparam int CW = (AMOUNT_WIDTH > ccd_pkg::DENOM_W) ? AMOUNT_WIDTH : ccd_pkg::DENOM_W;

  logic [AMOUNT_WIDTH-1:0] rem  [ccd_pkg::NUM_DENOMS+1];
  logic [CW-1:0]           rem_x[ccd_pkg::NUM_DENOMS];
  logic [CW-1:0]           den_x[ccd_pkg::NUM_DENOMS];
  logic [CW-1:0]           diff [ccd_pkg::NUM_DENOMS];

  always_comb begin
    rem[0] = pend_i;
    mask_o = '0;
    for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
      rem_x[i] = CW'(rem[i]);
      den_x[i] = CW'(denom_i[i]);
      diff[i]  = rem_x[i] - den_x[i];
      if (in_stock_i[i] && (denom_i[i] != '0) && (rem_x[i] >= den_x[i])) begin
        mask_o[i]  = 1'b1;
        rem[i+1]   = AMOUNT_WIDTH'(diff[i]);
      end else begin
        rem[i+1]   = rem[i];
      end
    end
    pend_o = rem[ccd_pkg::NUM_DENOMS];
  end

endmodule

### hdl/coin_change_dispenser_core.sv
// Coin change dispenser top level: stock counts, pending change, greedy passes.
// Depends on ccd_pkg, ccd_ifs (channel interfaces) and ccd_pass.
//
// Takes one item per cycle while the result side is not stalling and returns one
// result per item, through an input register and then a result register. Each item is
// resolved combinationally between those registers; the longest path is the chain of
// five compare-subtract steps of a dispense pass. Configuration writes take
// effect at the edge they are accepted; cfg ready is always high. Denomination
// values reset to 10000, 5000, 2000, 50 and 20 copecks.
module coin_change_dispenser_core #(
  parameter int COUNT_WIDTH  = ccd_pkg::COUNT_WIDTH_DEF,
  parameter int AMOUNT_WIDTH = ccd_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ccd_in_if.sink      in_ch,
  ccd_out_if.source   out_ch,
  ccd_cfg_if.sink     cfg_ch
);

  localparam int SW = (AMOUNT_WIDTH > ccd_pkg::AMT_W) ? AMOUNT_WIDTH : ccd_pkg::AMT_W;

  // input stage
  logic                      s1_valid_r, s1_valid_nxt;
  ccd_pkg::op_t              s1_op_r;
  logic [ccd_pkg::AMT_W-1:0] s1_amount_r;

  // result stage
  logic                      out_valid_r, out_valid_nxt;
  logic                      accepted_r, accepted_nxt;
  ccd_pkg::mask_t            mask_r, mask_nxt;
  logic [ccd_pkg::AMT_W-1:0] remaining_r, remaining_nxt;
  logic                      done_r, done_nxt;
  logic                      stuck_r, stuck_nxt;

  // block state
  ccd_pkg::denom_vec_t       denom_r;
  logic [COUNT_WIDTH-1:0]    cnt_r  [ccd_pkg::NUM_DENOMS];
  logic [COUNT_WIDTH-1:0]    cnt_nxt[ccd_pkg::NUM_DENOMS];
  logic [AMOUNT_WIDTH-1:0]   pending_r, pending_nxt;
  logic                      change_active_r, change_active_nxt;

  logic                      in_acc;
  logic                      adv;
  logic                      fire;
  ccd_pkg::mask_t            in_stock;
  ccd_pkg::mask_t            pass_mask;
  logic [AMOUNT_WIDTH-1:0]   pass_pend;
  logic [SW-1:0]             amt_x;
  logic                      matched;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign fire        = s1_valid_r && adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = accepted_r;
  assign out_ch.dispensed_mask = mask_r;
  assign out_ch.remaining      = remaining_r;
  assign out_ch.done_res       = done_r;
  assign out_ch.stuck          = stuck_r;

  always_comb begin
    for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
      in_stock[i] = (cnt_r[i] != '0);
    end
  end

  ccd_pass #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_pass (
    .pend_i     (pending_r),
    .denom_i    (denom_r),
    .in_stock_i (in_stock),
    .pend_o     (pass_pend),
    .mask_o     (pass_mask)
  );

  assign amt_x = SW'(s1_amount_r);

  always_comb begin
    s1_valid_nxt      = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt     = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    pending_nxt       = pending_r;
    change_active_nxt = change_active_r;
    for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    accepted_nxt = 1'b0;
    mask_nxt     = '0;
    done_nxt     = 1'b0;
    stuck_nxt    = 1'b0;
    matched      = 1'b0;
    remaining_nxt = ccd_pkg::AMT_W'(pending_r);

    case (s1_op_r)
      ccd_pkg::OP_DEPOSIT: begin
        for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
          if (!matched && (denom_r[i] != '0) &&
              (ccd_pkg::AMT_W'(denom_r[i]) == s1_amount_r)) begin
            matched = 1'b1;
            if (!(&cnt_r[i])) begin
              cnt_nxt[i] = cnt_r[i] + COUNT_WIDTH'(1);
            end
          end
        end
        accepted_nxt = matched;
      end
      ccd_pkg::OP_REQUEST: begin
        if (amt_x > SW'({AMOUNT_WIDTH{1'b1}})) begin
          pending_nxt = {AMOUNT_WIDTH{1'b1}};
        end else begin
          pending_nxt = AMOUNT_WIDTH'(s1_amount_r);
        end
        accepted_nxt      = 1'b1;
        change_active_nxt = (pending_nxt != '0);
        done_nxt          = (pending_nxt == '0);
        remaining_nxt     = ccd_pkg::AMT_W'(pending_nxt);
      end
      ccd_pkg::OP_TICK: begin
        if (change_active_r) begin
          accepted_nxt  = 1'b1;
          mask_nxt      = pass_mask;
          pending_nxt   = pass_pend;
          remaining_nxt = ccd_pkg::AMT_W'(pass_pend);
          for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
            if (pass_mask[i]) begin
              cnt_nxt[i] = cnt_r[i] - COUNT_WIDTH'(1);
            end
          end
          if (pass_pend == '0) begin
            done_nxt          = 1'b1;
            change_active_nxt = 1'b0;
          end else if (pass_mask == '0) begin
            // nothing fits: give up and report the shortfall
            stuck_nxt         = 1'b1;
            done_nxt          = 1'b1;
            change_active_nxt = 1'b0;
            pending_nxt       = '0;
          end
        end
      end
      ccd_pkg::OP_CLEAR: begin
        for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
          cnt_nxt[i] = '0;
        end
        accepted_nxt = 1'b1;
      end
      default: begin
        accepted_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      denom_r         <= ccd_pkg::DENOM_RESET;
      pending_r       <= '0;
      change_active_r <= 1'b0;
      for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        pending_r       <= pending_nxt;
        change_active_r <= change_active_nxt;
        for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
          if (cfg_ch.index == ccd_pkg::CFG_IDX_W'(i)) begin
            denom_r[i] <= cfg_ch.data;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_ch.op;
      s1_amount_r <= in_ch.amount;
    end
    if (fire) begin
      accepted_r  <= accepted_nxt;
      mask_r      <= mask_nxt;
      remaining_r <= remaining_nxt;
      done_r      <= done_nxt;
      stuck_r     <= stuck_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // no change owed while idle
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !change_active_r |-> (pending_r == '0))
    else $error("pending change nonzero with no change active");

  a_stuck_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && stuck_r) |-> (done_r && (mask_r == '0) && accepted_r))
    else $error("stuck result without done or with dispensed items");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_op_r) && $stable(s1_amount_r)))
    else $error("input stage lost an item under stall");

  a_mask_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (mask_r != '0)) |-> accepted_r)
    else $error("dispense reported on an item not taken");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for coin_change_dispenser_core: directed table, a back-to-back
// deposit run, then randomized phases under several denomination settings with random stalls.
// Depends on hdl/ccd_pkg.sv, hdl/ccd_ifs.sv and the core RTL.
module testbench;

  typedef logic [ccd_pkg::AMT_W-1:0]           copecks_t;
  typedef logic [ccd_pkg::COUNT_WIDTH_DEF-1:0] count_t;

  typedef struct packed {
    logic            accepted;
    ccd_pkg::mask_t  dispensed_mask;
    copecks_t        remaining;
    logic            done_res;
    logic            stuck;
  } coin_result_t;

  typedef struct packed {
    ccd_pkg::op_t    op;
    copecks_t        amount;
    logic            pinned;
    logic            acc;
    ccd_pkg::mask_t  mask;
    copecks_t        rem;
    logic            fin;
    logic            stk;
  } stim_row_t;

  localparam ccd_pkg::cfg_idx_t REG_SMALL_COIN   = 3'd4;
  localparam ccd_pkg::cfg_idx_t REG_FIRST_UNUSED = 3'd5;
  localparam int                FILL_ITEMS       = 24;
  localparam int                RANDOM_PHASES    = 8;
  localparam int                ITEMS_PER_PHASE  = 240;

  localparam ccd_pkg::denom_vec_t DENOM_EXTREMES =
    {16'h0000, 16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF};

  // pinned rows carry their own expectation; the rest go to the predictor
  localparam stim_row_t DIRECTED [26] = '{
    '{ccd_pkg::OP_TICK,    20'd0,     1'b1, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_REQUEST, 20'd0,     1'b1, 1'b1, 5'd0, 20'd0,     1'b1, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd0,     1'b1, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'hFFFFF, 1'b1, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd10000, 1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd5000,  1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd2000,  1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd50,    1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd20,    1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd20,    1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_REQUEST, 20'hFFFFF, 1'b1, 1'b1, 5'd0, 20'hFFFFF, 1'b0, 1'b0},
    '{ccd_pkg::OP_TICK,    20'd0,     1'b0, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_TICK,    20'hABCDE, 1'b0, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_TICK,    20'd0,     1'b0, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_TICK,    20'd0,     1'b1, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd50,    1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd20,    1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_REQUEST, 20'd70,    1'b1, 1'b1, 5'd0, 20'd70,    1'b0, 1'b0},
    '{ccd_pkg::OP_TICK,    20'd0,     1'b0, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_DEPOSIT, 20'd20,    1'b1, 1'b1, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_REQUEST, 20'd100,   1'b1, 1'b1, 5'd0, 20'd100,   1'b0, 1'b0},
    '{ccd_pkg::OP_REQUEST, 20'd30,    1'b1, 1'b1, 5'd0, 20'd30,    1'b0, 1'b0},
    '{ccd_pkg::OP_TICK,    20'd0,     1'b0, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0},
    '{ccd_pkg::OP_CLEAR,   20'h55555, 1'b1, 1'b1, 5'd0, 20'd10,    1'b0, 1'b0},
    '{ccd_pkg::OP_TICK,    20'd0,     1'b1, 1'b1, 5'd0, 20'd10,    1'b1, 1'b1},
    '{ccd_pkg::OP_TICK,    20'd0,     1'b1, 1'b0, 5'd0, 20'd0,     1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  ccd_in_if  in_ch ();
  ccd_out_if out_ch ();
  ccd_cfg_if cfg_ch ();

  coin_change_dispenser_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow state of the dispenser
  ccd_pkg::denom_t denom_val [ccd_pkg::NUM_DENOMS];
  count_t          stock [ccd_pkg::NUM_DENOMS];
  copecks_t        owed;
  logic            change_on;

  coin_result_t pending_results [$];
  int           mismatches = 0;

  logic         pin_known;
  coin_result_t pin_want;
  bit           burst     = 1'b0;
  bit           in_quiet  = 1'b0;
  bit           out_quiet = 1'b0;
  int           chase     = 0;

  function automatic coin_result_t predict_change(ccd_pkg::op_t op, copecks_t amt);
    coin_result_t r;
    logic         hit;
    int           i;
    r   = '0;
    hit = 1'b0;
    case (op)
      ccd_pkg::OP_DEPOSIT: begin
        for (i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
          if (!hit && denom_val[i] != '0 && copecks_t'(denom_val[i]) == amt) begin
            hit = 1'b1;
            if (stock[i] != '1) stock[i] = stock[i] + 1'b1;
          end
        end
        r.accepted  = hit;
        r.remaining = owed;
      end
      ccd_pkg::OP_REQUEST: begin
        owed        = amt;
        change_on   = (amt != '0);
        r.accepted  = 1'b1;
        r.done_res  = (amt == '0);
        r.remaining = owed;
      end
      ccd_pkg::OP_TICK: begin
        if (change_on) begin
          r.accepted = 1'b1;
          for (i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
            if (denom_val[i] != '0 && stock[i] != '0 && owed >= copecks_t'(denom_val[i])) begin
              owed                = owed - copecks_t'(denom_val[i]);
              stock[i]            = stock[i] - 1'b1;
              r.dispensed_mask[i] = 1'b1;
            end
          end
          if (owed == '0) begin
            r.done_res = 1'b1;
            change_on  = 1'b0;
          end else if (r.dispensed_mask == '0) begin
            r.stuck    = 1'b1;
            r.done_res = 1'b1;
            change_on  = 1'b0;
          end
        end
        r.remaining = owed;
        if (r.stuck) owed = '0;
      end
      ccd_pkg::OP_CLEAR: begin
        for (i = 0; i < ccd_pkg::NUM_DENOMS; i++) stock[i] = '0;
        r.accepted  = 1'b1;
        r.remaining = owed;
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // prediction at acceptance, checking at result handshake
  always @(posedge clk) begin
    coin_result_t pred;
    coin_result_t want;
    int           i;
    if (!rst_n) begin
      for (i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
        denom_val[i] = ccd_pkg::DENOM_RESET[i];
        stock[i]     = '0;
      end
      owed      = '0;
      change_on = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < ccd_pkg::NUM_DENOMS)
        denom_val[cfg_ch.index] = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        pred = predict_change(in_ch.op, in_ch.amount);
        pending_results.push_back(pin_known ? pin_want : pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, actual %0h", $time,
                   {out_ch.accepted, out_ch.dispensed_mask, out_ch.remaining,
                    out_ch.done_res, out_ch.stuck});
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("accepted", want.accepted, out_ch.accepted);
          compare_field("dispensed_mask", want.dispensed_mask, out_ch.dispensed_mask);
          compare_field("remaining", want.remaining, out_ch.remaining);
          compare_field("done_res", want.done_res, out_ch.done_res);
          compare_field("stuck", want.stuck, out_ch.stuck);
        end
      end
    end
  end

  // result side backpressure
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = (burst || out_quiet) ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(ccd_pkg::op_t op, copecks_t amt, logic known, coin_result_t want);
    int gap;
    gap = (burst || in_quiet) ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.amount <= amt;
    pin_known    <= known;
    pin_want     <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic program_denoms(ccd_pkg::denom_vec_t vals);
    int i;
    for (i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= ccd_pkg::cfg_idx_t'(i);
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    // out-of-range index must leave the denominations alone
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_FIRST_UNUSED + ccd_pkg::cfg_idx_t'($urandom_range(0, 2));
    cfg_ch.data  <= ccd_pkg::denom_t'($urandom);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item();
    int       pick;
    int       k;
    copecks_t amt;
    pick = $urandom_range(0, 99);
    if (chase > 0 && pick < 60) begin
      chase--;
      send_item(ccd_pkg::OP_TICK, copecks_t'($urandom), 1'b0, '0);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item(ccd_pkg::OP_DEPOSIT,
                  copecks_t'(denom_val[$urandom_range(0, ccd_pkg::NUM_DENOMS - 1)]),
                  1'b0, '0);
      end else if (pick < 46) begin
        send_item(ccd_pkg::OP_DEPOSIT, copecks_t'($urandom), 1'b0, '0);
      end else if (pick < 62) begin
        case ($urandom_range(0, 3))
          0, 1: begin
            amt = '0;
            k   = $urandom_range(0, 5);
            repeat (k)
              amt = amt + copecks_t'(denom_val[$urandom_range(0, ccd_pkg::NUM_DENOMS - 1)]);
          end
          2: amt = copecks_t'($urandom);
          default: amt = copecks_t'($urandom_range(0, 300));
        endcase
        chase = $urandom_range(1, 10);
        send_item(ccd_pkg::OP_REQUEST, amt, 1'b0, '0);
      end else if (pick < 97) begin
        send_item(ccd_pkg::OP_TICK, copecks_t'($urandom), 1'b0, '0);
      end else begin
        send_item(ccd_pkg::OP_CLEAR, copecks_t'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin
    int                  n;
    int                  ph;
    int                  i;
    int                  r;
    ccd_pkg::denom_vec_t set;
    coin_result_t        want;
    in_ch.valid  = 1'b0;
    in_ch.op     = ccd_pkg::OP_DEPOSIT;
    in_ch.amount = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    pin_known    = 1'b0;
    pin_want     = '0;
    rst_n        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < $size(DIRECTED); n++) begin
      want = '{DIRECTED[n].acc, DIRECTED[n].mask, DIRECTED[n].rem,
               DIRECTED[n].fin, DIRECTED[n].stk};
      send_item(DIRECTED[n].op, DIRECTED[n].amount, DIRECTED[n].pinned, want);
    end
    drain();

    // back-to-back deposits of one coin, then change drawn one coin per pass
    burst = 1'b1;
    repeat (FILL_ITEMS)
      send_item(ccd_pkg::OP_DEPOSIT, copecks_t'(denom_val[REG_SMALL_COIN]), 1'b0, '0);
    burst = 1'b0;
    send_item(ccd_pkg::OP_REQUEST, copecks_t'(6 * denom_val[REG_SMALL_COIN]), 1'b0, '0);
    repeat (7) send_item(ccd_pkg::OP_TICK, '0, 1'b0, '0);
    send_item(ccd_pkg::OP_CLEAR, '0, 1'b0, '0);
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0, RANDOM_PHASES - 1: set = ccd_pkg::DENOM_RESET;
        1: set = DENOM_EXTREMES;
        2: set = '0;
        default: begin
          for (i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
            r = $urandom_range(0, 15);
            if (r == 0) set[i] = '0;
            else if (r < 5) set[i] = ccd_pkg::denom_t'($urandom_range(1, 200));
            else if (r == 5) set[i] = '1;
            else set[i] = ccd_pkg::denom_t'($urandom);
          end
        end
      endcase
      program_denoms(set);
      chase = 0;
      repeat (ITEMS_PER_PHASE) begin
        random_item();
        if ($urandom_range(0, 149) == 0) drain();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS coin_change_dispenser_core");
    end else begin
      $display("FAIL coin_change_dispenser_core");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL coin_change_dispenser_core");
    $finish;
  end

endmodule
